/* sv/event_keyed_state_table_top_macros.svh */
// Assertion macros for the event keyed state table.
`ifndef EVENT_KEYED_STATE_TABLE_TOP_MACROS_SVH
`define EVENT_KEYED_STATE_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define EKST_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EKST_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EKST_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define EKST_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

/* sv/ekst_pkg.sv */
// Types, codes and command/status structs of the event keyed state table.
package ekst_pkg;

  localparam int unsigned MS_TO_US = 1000;
  localparam int unsigned LIMIT_W  = 42;

  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_NORMAL  = 2'd1;
  localparam logic [1:0] ST_REVERSE = 2'd2;
  localparam logic [1:0] ST_STALE   = 2'd3;

  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_SWAP    = 3'd2,
    ACT_EVENT   = 3'd3,
    ACT_FIND    = 3'd4,
    ACT_SETPEND = 3'd5,
    ACT_STALE   = 3'd6,
    ACT_READ    = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    RES_OK      = 3'd0,
    RES_FULL    = 3'd1,
    RES_DUP     = 3'd2,
    RES_BAD_IDX = 3'd3,
    RES_NOMATCH = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RD, S_CHK, S_END, S_SH_RD, S_SH_WR,
    S_SW_A, S_SW_B, S_SW_WA, S_SW_WB, S_ONE_RD, S_ONE
  } fsm_t;

  typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_IA, IDX_INC} idx_op_t;
  typedef enum logic [1:0] {RA_IDX, RA_IDX1, RA_IA, RA_IB} ra_sel_t;
  typedef enum logic [1:0] {WA_IDX, WA_IA, WA_IB, WA_FILL} wa_sel_t;
  typedef enum logic [2:0] {
    DAT_RDATA, DAT_TMP, DAT_EVENT, DAT_PEND, DAT_STALE, DAT_NEW
  } dsel_t;
  typedef enum logic [1:0] {FILL_HOLD, FILL_INC, FILL_DEC} fill_op_t;
  typedef enum logic [1:0] {IX_IDX, IX_IA, IX_ZERO} ix_sel_t;

  typedef struct packed {
    logic [63:0] key_n;
    logic [63:0] key_r;
    logic [1:0]  st;
    logic        pend;
    logic [47:0] tm;
  } entry_t;

  typedef struct packed {
    logic     load_in;
    idx_op_t  idx_op;
    logic     rd_en;
    ra_sel_t  ra_sel;
    logic     wr_en;
    wa_sel_t  wa_sel;
    dsel_t    dsel;
    logic     save_tmp;
    fill_op_t fill_op;
    logic     emit;
    status_t  status;
    ix_sel_t  ix_sel;
    logic     show;
    logic     notify;
    logic     last;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    full;
    logic    ia_bad;
    logic    ib_bad;
    logic    idx_end;
    logic    shift_end;
    logic    dup;
    logic    hit;
    logic    stale;
    logic    aging_off;
    logic    out_busy;
  } sts_t;

endpackage

/* sv/event_keyed_state_table_top.sv */
// Top level of the event keyed state table: controller, datapath and checks.
// One transaction is taken at a time. Add, event, find and stale check scan the
// table through the entry memory, one entry after another; stale check skips the
// scan while aging is off. Remove shifts each entry above the removed one down.
// A ready result waits in its final state while a stalled output register still
// holds the last result. A new transaction is taken while the last result still
// waits in the output register.
`include "event_keyed_state_table_top_macros.svh"
module event_keyed_state_table_top #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [63:0] in_key_a,
  input  logic [63:0] in_key_b,
  input  logic [4:0]  in_index_a,
  input  logic [4:0]  in_index_b,
  input  logic        in_pending_flag,
  input  logic [47:0] in_current_time,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [4:0]  out_entry_index,
  output logic [1:0]  out_entry_state,
  output logic        out_entry_pending,
  output logic [63:0] out_entry_key_normal,
  output logic [63:0] out_entry_key_reverse,
  output logic [47:0] out_entry_time,
  output logic [5:0]  out_entry_count,
  output logic        out_notify,
  output logic        out_last
);

  ekst_pkg::cmd_t cmd;
  ekst_pkg::sts_t sts;

  ekst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ekst_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_action             (in_action),
    .in_key_a              (in_key_a),
    .in_key_b              (in_key_b),
    .in_index_a            (in_index_a),
    .in_index_b            (in_index_b),
    .in_pending_flag       (in_pending_flag),
    .in_current_time       (in_current_time),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_entry_index       (out_entry_index),
    .out_entry_state       (out_entry_state),
    .out_entry_pending     (out_entry_pending),
    .out_entry_key_normal  (out_entry_key_normal),
    .out_entry_key_reverse (out_entry_key_reverse),
    .out_entry_time        (out_entry_time),
    .out_entry_count       (out_entry_count),
    .out_notify            (out_notify),
    .out_last              (out_last)
  );

  `EKST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `EKST_ASSERT_IMPL(a_count_in_range, clk, rst_n, out_valid, out_entry_count <= 6'(DEPTH))
  `EKST_ASSERT_IMPL(a_notify_only_ok, clk, rst_n, out_valid && out_notify, out_status == ekst_pkg::RES_OK)
  `EKST_ASSERT_IMPL(a_reject_no_data, clk, rst_n, out_valid && (out_status != ekst_pkg::RES_OK), out_entry_key_normal == 64'd0 && out_entry_time == 48'd0 && out_last)

endmodule

/* sv/ekst_datapath.sv */
// Datapath of the event keyed state table: entry memory, scan index and result register.
module ekst_datapath #(
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ekst_pkg::cmd_t       cmd,
  output ekst_pkg::sts_t       sts,
  input  logic [2:0]           in_action,
  input  logic [63:0]          in_key_a,
  input  logic [63:0]          in_key_b,
  input  logic [4:0]           in_index_a,
  input  logic [4:0]           in_index_b,
  input  logic                 in_pending_flag,
  input  logic [47:0]          in_current_time,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [4:0]           out_entry_index,
  output logic [1:0]           out_entry_state,
  output logic                 out_entry_pending,
  output logic [63:0]          out_entry_key_normal,
  output logic [63:0]          out_entry_key_reverse,
  output logic [47:0]          out_entry_time,
  output logic [5:0]           out_entry_count,
  output logic                 out_notify,
  output logic                 out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ekst_pkg::entry_t mem [DEPTH];

  ekst_pkg::action_t            act_r;
  logic [63:0]                  ka_r;
  logic [63:0]                  kb_r;
  logic [4:0]                   ia_r;
  logic [4:0]                   ib_r;
  logic                         pf_r;
  logic [47:0]                  now_r;
  logic [ekst_pkg::LIMIT_W-1:0] limit_r;
  logic [CW-1:0]                fill_r;
  logic [CW-1:0]                fill_nxt;
  logic [CW-1:0]                idx_r;
  ekst_pkg::entry_t             rdata_r;
  ekst_pkg::entry_t             tmp_r;
  ekst_pkg::entry_t             dat;
  logic [CW-1:0]                raddr;
  logic [CW-1:0]                waddr;
  logic [47:0]                  age;
  logic                         hit_n;
  logic                         hit_r;
  logic                         out_valid_r;
  logic [2:0]                   out_status_r;
  logic [4:0]                   out_index_r;
  ekst_pkg::entry_t             out_entry_r;
  logic [5:0]                   out_count_r;
  logic                         out_notify_r;
  logic                         out_last_r;
  logic [4:0]                   ix;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= ekst_pkg::action_t'(in_action);
      ka_r  <= in_key_a;
      kb_r  <= in_key_b;
      ia_r  <= in_index_a;
      ib_r  <= in_index_b;
      pf_r  <= in_pending_flag;
      now_r <= in_current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_wr_en) begin
      limit_r <= ekst_pkg::LIMIT_W'(cfg_wr_data) * ekst_pkg::LIMIT_W'(ekst_pkg::MS_TO_US);
    end
  end

  assign hit_n = (rdata_r.key_n == ka_r);
  assign hit_r = (rdata_r.key_r == ka_r);
  assign age   = now_r - rdata_r.tm;

  always_comb begin
    sts.act       = act_r;
    sts.full      = (fill_r == CW'(DEPTH));
    sts.ia_bad    = ({1'b0, ia_r} >= 6'(fill_r));
    sts.ib_bad    = ({1'b0, ib_r} >= 6'(fill_r));
    sts.idx_end   = (idx_r >= fill_r);
    sts.shift_end = ((idx_r + CW'(1)) >= fill_r);
    sts.dup       = hit_n || (rdata_r.key_r == kb_r);
    sts.hit       = hit_n || hit_r;
    sts.stale     = (rdata_r.tm != 48'd0) &&
                    ((rdata_r.st == ekst_pkg::ST_NORMAL) ||
                     (rdata_r.st == ekst_pkg::ST_REVERSE)) &&
                    (now_r > rdata_r.tm) && (age > {6'd0, limit_r});
    sts.aging_off = (limit_r == '0);
    sts.out_busy  = out_valid_r && out_stall;
  end

  always_comb begin
    dat = rdata_r;
    case (cmd.dsel)
      ekst_pkg::DAT_RDATA: dat = rdata_r;
      ekst_pkg::DAT_TMP:   dat = tmp_r;
      ekst_pkg::DAT_EVENT: begin
        dat.st   = hit_n ? ekst_pkg::ST_NORMAL : ekst_pkg::ST_REVERSE;
        dat.tm   = now_r;
        dat.pend = 1'b0;
      end
      ekst_pkg::DAT_PEND:  dat.pend = pf_r;
      ekst_pkg::DAT_STALE: dat.st = ekst_pkg::ST_STALE;
      ekst_pkg::DAT_NEW: begin
        dat       = '0;
        dat.key_n = ka_r;
        dat.key_r = kb_r;
      end
      default: dat = '0;
    endcase
  end

  always_comb begin
    case (cmd.ra_sel)
      ekst_pkg::RA_IDX:  raddr = idx_r;
      ekst_pkg::RA_IDX1: raddr = idx_r + CW'(1);
      ekst_pkg::RA_IA:   raddr = CW'(ia_r);
      ekst_pkg::RA_IB:   raddr = CW'(ib_r);
      default:           raddr = idx_r;
    endcase
    case (cmd.wa_sel)
      ekst_pkg::WA_IDX:  waddr = idx_r;
      ekst_pkg::WA_IA:   waddr = CW'(ia_r);
      ekst_pkg::WA_IB:   waddr = CW'(ib_r);
      ekst_pkg::WA_FILL: waddr = fill_r;
      default:           waddr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr[AW-1:0]] <= dat;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr[AW-1:0]];
    end
    if (cmd.save_tmp) begin
      tmp_r <= rdata_r;
    end
  end

  always_comb begin
    case (cmd.fill_op)
      ekst_pkg::FILL_INC: fill_nxt = fill_r + CW'(1);
      ekst_pkg::FILL_DEC: fill_nxt = fill_r - CW'(1);
      default:            fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      idx_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      case (cmd.idx_op)
        ekst_pkg::IDX_ZERO: idx_r <= '0;
        ekst_pkg::IDX_IA:   idx_r <= CW'(ia_r);
        ekst_pkg::IDX_INC:  idx_r <= idx_r + CW'(1);
        default:            idx_r <= idx_r;
      endcase
    end
  end

  always_comb begin
    case (cmd.ix_sel)
      ekst_pkg::IX_IDX: ix = 5'(idx_r);
      ekst_pkg::IX_IA:  ix = ia_r;
      default:          ix = 5'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit && !sts.out_busy) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && !sts.out_busy) begin
      out_status_r <= cmd.status;
      out_index_r  <= ix;
      out_entry_r  <= cmd.show ? dat : '0;
      out_count_r  <= 6'(fill_nxt);
      out_notify_r <= cmd.notify;
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_entry_index       = out_index_r;
  assign out_entry_state       = out_entry_r.st;
  assign out_entry_pending     = out_entry_r.pend;
  assign out_entry_key_normal  = out_entry_r.key_n;
  assign out_entry_key_reverse = out_entry_r.key_r;
  assign out_entry_time        = out_entry_r.tm;
  assign out_entry_count       = out_count_r;
  assign out_notify            = out_notify_r;
  assign out_last              = out_last_r;

endmodule

/* sv/ekst_ctrl.sv */
// Controller state machine of the event keyed state table.
module ekst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ekst_pkg::sts_t sts,
  output ekst_pkg::cmd_t cmd
);

  ekst_pkg::fsm_t state_r;
  ekst_pkg::fsm_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ekst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      ekst_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ekst_pkg::S_DISP;
        end
      end
      ekst_pkg::S_DISP: begin
        case (sts.act)
          ekst_pkg::ACT_ADD: begin
            if (sts.full) begin
              cmd.emit   = !sts.out_busy;
              cmd.status = ekst_pkg::RES_FULL;
              cmd.ix_sel = ekst_pkg::IX_ZERO;
              cmd.last   = 1'b1;
              if (!sts.out_busy) state_nxt = ekst_pkg::S_IDLE;
            end else begin
              cmd.idx_op = ekst_pkg::IDX_ZERO;
              state_nxt  = ekst_pkg::S_RD;
            end
          end
          ekst_pkg::ACT_EVENT, ekst_pkg::ACT_FIND: begin
            cmd.idx_op = ekst_pkg::IDX_ZERO;
            state_nxt  = ekst_pkg::S_RD;
          end
          ekst_pkg::ACT_STALE: begin
            cmd.idx_op = ekst_pkg::IDX_ZERO;
            state_nxt  = sts.aging_off ? ekst_pkg::S_END : ekst_pkg::S_RD;
          end
          default: begin
            if (sts.ia_bad || ((sts.act == ekst_pkg::ACT_SWAP) && sts.ib_bad)) begin
              cmd.emit   = !sts.out_busy;
              cmd.status = ekst_pkg::RES_BAD_IDX;
              cmd.ix_sel = ekst_pkg::IX_IA;
              cmd.last   = 1'b1;
              if (!sts.out_busy) state_nxt = ekst_pkg::S_IDLE;
            end else if (sts.act == ekst_pkg::ACT_REMOVE) begin
              cmd.idx_op = ekst_pkg::IDX_IA;
              state_nxt  = ekst_pkg::S_SH_RD;
            end else if (sts.act == ekst_pkg::ACT_SWAP) begin
              state_nxt = ekst_pkg::S_SW_A;
            end else begin
              state_nxt = ekst_pkg::S_ONE_RD;
            end
          end
        endcase
      end
      ekst_pkg::S_RD: begin
        if (sts.idx_end) begin
          state_nxt = ekst_pkg::S_END;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = ekst_pkg::RA_IDX;
          state_nxt  = ekst_pkg::S_CHK;
        end
      end
      ekst_pkg::S_CHK: begin
        cmd.ix_sel = ekst_pkg::IX_IDX;
        cmd.last   = 1'b1;
        case (sts.act)
          ekst_pkg::ACT_ADD: begin
            if (sts.dup) begin
              cmd.emit   = !sts.out_busy;
              cmd.status = ekst_pkg::RES_DUP;
              if (!sts.out_busy) state_nxt = ekst_pkg::S_IDLE;
            end else begin
              cmd.idx_op = ekst_pkg::IDX_INC;
              state_nxt  = ekst_pkg::S_RD;
            end
          end
          ekst_pkg::ACT_EVENT: begin
            if (sts.hit) begin
              cmd.dsel   = ekst_pkg::DAT_EVENT;
              cmd.wa_sel = ekst_pkg::WA_IDX;
              cmd.wr_en  = !sts.out_busy;
              cmd.emit   = !sts.out_busy;
              cmd.show   = 1'b1;
              cmd.notify = 1'b1;
              if (!sts.out_busy) state_nxt = ekst_pkg::S_IDLE;
            end else begin
              cmd.idx_op = ekst_pkg::IDX_INC;
              state_nxt  = ekst_pkg::S_RD;
            end
          end
          ekst_pkg::ACT_FIND: begin
            if (sts.hit) begin
              cmd.dsel = ekst_pkg::DAT_RDATA;
              cmd.emit = !sts.out_busy;
              cmd.show = 1'b1;
              if (!sts.out_busy) state_nxt = ekst_pkg::S_IDLE;
            end else begin
              cmd.idx_op = ekst_pkg::IDX_INC;
              state_nxt  = ekst_pkg::S_RD;
            end
          end
          ekst_pkg::ACT_STALE: begin
            cmd.last = 1'b0;
            if (sts.stale) begin
              cmd.dsel   = ekst_pkg::DAT_STALE;
              cmd.wa_sel = ekst_pkg::WA_IDX;
              cmd.show   = 1'b1;
              cmd.notify = 1'b1;
              if (!sts.out_busy) begin
                cmd.wr_en  = 1'b1;
                cmd.emit   = 1'b1;
                cmd.idx_op = ekst_pkg::IDX_INC;
                state_nxt  = ekst_pkg::S_RD;
              end
            end else begin
              cmd.idx_op = ekst_pkg::IDX_INC;
              state_nxt  = ekst_pkg::S_RD;
            end
          end
          default: state_nxt = ekst_pkg::S_IDLE;
        endcase
      end
      ekst_pkg::S_END: begin
        cmd.last = 1'b1;
        case (sts.act)
          ekst_pkg::ACT_ADD: begin
            cmd.dsel   = ekst_pkg::DAT_NEW;
            cmd.wa_sel = ekst_pkg::WA_FILL;
            cmd.ix_sel = ekst_pkg::IX_IDX;
            cmd.show   = 1'b1;
            if (!sts.out_busy) begin
              cmd.wr_en   = 1'b1;
              cmd.fill_op = ekst_pkg::FILL_INC;
            end
          end
          ekst_pkg::ACT_STALE: cmd.ix_sel = ekst_pkg::IX_ZERO;
          default: begin
            cmd.status = ekst_pkg::RES_NOMATCH;
            cmd.ix_sel = ekst_pkg::IX_ZERO;
          end
        endcase
        cmd.emit = !sts.out_busy;
        if (!sts.out_busy) state_nxt = ekst_pkg::S_IDLE;
      end
      ekst_pkg::S_SH_RD: begin
        if (sts.shift_end) begin
          cmd.ix_sel = ekst_pkg::IX_IA;
          cmd.last   = 1'b1;
          if (!sts.out_busy) begin
            cmd.emit    = 1'b1;
            cmd.fill_op = ekst_pkg::FILL_DEC;
            state_nxt   = ekst_pkg::S_IDLE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = ekst_pkg::RA_IDX1;
          state_nxt  = ekst_pkg::S_SH_WR;
        end
      end
      ekst_pkg::S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = ekst_pkg::WA_IDX;
        cmd.dsel   = ekst_pkg::DAT_RDATA;
        cmd.idx_op = ekst_pkg::IDX_INC;
        state_nxt  = ekst_pkg::S_SH_RD;
      end
      ekst_pkg::S_SW_A: begin
        cmd.rd_en  = 1'b1;
        cmd.ra_sel = ekst_pkg::RA_IA;
        state_nxt  = ekst_pkg::S_SW_B;
      end
      ekst_pkg::S_SW_B: begin
        cmd.save_tmp = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.ra_sel   = ekst_pkg::RA_IB;
        state_nxt    = ekst_pkg::S_SW_WA;
      end
      ekst_pkg::S_SW_WA: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = ekst_pkg::WA_IA;
        cmd.dsel   = ekst_pkg::DAT_RDATA;
        state_nxt  = ekst_pkg::S_SW_WB;
      end
      ekst_pkg::S_SW_WB: begin
        cmd.wa_sel = ekst_pkg::WA_IB;
        cmd.dsel   = ekst_pkg::DAT_TMP;
        cmd.ix_sel = ekst_pkg::IX_IA;
        cmd.last   = 1'b1;
        if (!sts.out_busy) begin
          cmd.wr_en = 1'b1;
          cmd.emit  = 1'b1;
          state_nxt = ekst_pkg::S_IDLE;
        end
      end
      ekst_pkg::S_ONE_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.ra_sel = ekst_pkg::RA_IA;
        state_nxt  = ekst_pkg::S_ONE;
      end
      ekst_pkg::S_ONE: begin
        cmd.ix_sel = ekst_pkg::IX_IA;
        cmd.wa_sel = ekst_pkg::WA_IA;
        cmd.show   = 1'b1;
        cmd.last   = 1'b1;
        cmd.dsel   = (sts.act == ekst_pkg::ACT_SETPEND) ? ekst_pkg::DAT_PEND
                                                        : ekst_pkg::DAT_RDATA;
        if (!sts.out_busy) begin
          cmd.wr_en = (sts.act == ekst_pkg::ACT_SETPEND);
          cmd.emit  = 1'b1;
          state_nxt = ekst_pkg::S_IDLE;
        end
      end
      default: state_nxt = ekst_pkg::S_IDLE;
    endcase
  end

endmodule

/* tb/event_keyed_state_table_checker.sv */
// Checker for the event keyed state table: tracks the table, predicts and compares results.
module event_keyed_state_table_checker
  import ekst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [63:0] in_key_a,
  input  logic [63:0] in_key_b,
  input  logic [4:0]  in_index_a,
  input  logic [4:0]  in_index_b,
  input  logic        in_pending_flag,
  input  logic [47:0] in_current_time,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [4:0]  out_entry_index,
  input  logic [1:0]  out_entry_state,
  input  logic        out_entry_pending,
  input  logic [63:0] out_entry_key_normal,
  input  logic [63:0] out_entry_key_reverse,
  input  logic [47:0] out_entry_time,
  input  logic [5:0]  out_entry_count,
  input  logic        out_notify,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_results,
  output int          stale_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t     status;
    logic [4:0]  idx;
    logic [1:0]  st;
    logic        pend;
    logic [63:0] kn;
    logic [63:0] kr;
    logic [47:0] tm;
    logic [5:0]  cnt;
    logic        notify;
    logic        last;
  } table_reply_t;

  entry_t       tbl [32];
  int           fill;
  logic [31:0]  aging_limit_ms;
  table_reply_t replies_due [$];

  function automatic table_reply_t make_reply(status_t s, int idx, bit show,
                                              bit ntf, bit lst);
    table_reply_t r;
    r = '0;
    r.status = s;
    r.idx = idx[4:0];
    if (show && idx < fill) begin
      r.st = tbl[idx].st;
      r.pend = tbl[idx].pend;
      r.kn = tbl[idx].key_n;
      r.kr = tbl[idx].key_r;
      r.tm = tbl[idx].tm;
    end
    r.cnt = fill[5:0];
    r.notify = ntf;
    r.last = lst;
    return r;
  endfunction

  task automatic apply_action();
    int ia, ib, i;
    bit done;
    logic [1:0] ns;
    logic [47:0] now;
    logic [63:0] limit;
    entry_t t;
    ia = in_index_a;
    ib = in_index_b;
    now = in_current_time;
    done = 0;
    case (action_t'(in_action))
      ACT_ADD: begin
        if (fill >= 32) begin
          replies_due.push_back(make_reply(RES_FULL, 0, 0, 0, 1));
        end else begin
          for (i = 0; i < fill && !done; i++)
            if (tbl[i].key_n == in_key_a || tbl[i].key_r == in_key_b) begin
              replies_due.push_back(make_reply(RES_DUP, i, 0, 0, 1));
              done = 1;
            end
          if (!done) begin
            tbl[fill] = '{key_n: in_key_a, key_r: in_key_b, st: ST_UNKNOWN,
                          pend: 1'b0, tm: '0};
            fill++;
            replies_due.push_back(make_reply(RES_OK, fill - 1, 1, 0, 1));
          end
        end
      end
      ACT_REMOVE: begin
        if (ia >= fill) begin
          replies_due.push_back(make_reply(RES_BAD_IDX, ia, 0, 0, 1));
        end else begin
          for (i = ia; i + 1 < fill; i++) tbl[i] = tbl[i + 1];
          fill--;
          replies_due.push_back(make_reply(RES_OK, ia, 0, 0, 1));
        end
      end
      ACT_SWAP: begin
        if (ia >= fill || ib >= fill) begin
          replies_due.push_back(make_reply(RES_BAD_IDX, ia, 0, 0, 1));
        end else begin
          t = tbl[ia];
          tbl[ia] = tbl[ib];
          tbl[ib] = t;
          replies_due.push_back(make_reply(RES_OK, ia, 0, 0, 1));
        end
      end
      ACT_EVENT: begin
        for (i = 0; i < fill && !done; i++) begin
          ns = (in_key_a == tbl[i].key_n) ? ST_NORMAL :
               (in_key_a == tbl[i].key_r) ? ST_REVERSE : ST_UNKNOWN;
          if (ns != ST_UNKNOWN) begin
            tbl[i].st = ns;
            tbl[i].tm = now;
            tbl[i].pend = 1'b0;
            replies_due.push_back(make_reply(RES_OK, i, 1, 1, 1));
            done = 1;
          end
        end
        if (!done) replies_due.push_back(make_reply(RES_NOMATCH, 0, 0, 0, 1));
      end
      ACT_FIND: begin
        for (i = 0; i < fill && !done; i++)
          if (tbl[i].key_n == in_key_a || tbl[i].key_r == in_key_a) begin
            replies_due.push_back(make_reply(RES_OK, i, 1, 0, 1));
            done = 1;
          end
        if (!done) replies_due.push_back(make_reply(RES_NOMATCH, 0, 0, 0, 1));
      end
      ACT_SETPEND: begin
        if (ia >= fill) begin
          replies_due.push_back(make_reply(RES_BAD_IDX, ia, 0, 0, 1));
        end else begin
          tbl[ia].pend = in_pending_flag;
          replies_due.push_back(make_reply(RES_OK, ia, 1, 0, 1));
        end
      end
      ACT_STALE: begin
        if (aging_limit_ms != 0) begin
          limit = 64'(aging_limit_ms) * 64'd1000;
          for (i = 0; i < fill; i++)
            if (tbl[i].tm != 0 && (tbl[i].st == ST_NORMAL || tbl[i].st == ST_REVERSE)
                && now > tbl[i].tm && 64'(now - tbl[i].tm) > limit) begin
              tbl[i].st = ST_STALE;
              replies_due.push_back(make_reply(RES_OK, i, 1, 1, 0));
              stale_reports++;
            end
        end
        replies_due.push_back(make_reply(RES_OK, 0, 0, 0, 1));
      end
      default: begin
        if (ia >= fill) replies_due.push_back(make_reply(RES_BAD_IDX, ia, 0, 0, 1));
        else replies_due.push_back(make_reply(RES_OK, ia, 1, 0, 1));
      end
    endcase
  endtask

  task automatic compare_reply();
    table_reply_t got, want;
    got = '{status: status_t'(out_status), idx: out_entry_index, st: out_entry_state,
            pend: out_entry_pending, kn: out_entry_key_normal,
            kr: out_entry_key_reverse, tm: out_entry_time, cnt: out_entry_count,
            notify: out_notify, last: out_last};
    if (replies_due.size() == 0) begin
      $display("%0t: unexpected result, actual %p", $time, got);
      fail_count++;
    end else begin
      want = replies_due.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch, expected %p", $time, want);
        $display("%0t:           actual   %p", $time, got);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      aging_limit_ms = '0;
      replies_due.delete();
      fail_count = 0;
      stale_reports = 0;
    end else begin
      if (out_valid && !out_stall) compare_reply();
      if (cfg_wr_en) aging_limit_ms = cfg_wr_data;
      if (in_valid && !in_stall) apply_action();
    end
    pending_results = replies_due.size();
  end
endmodule

/* tb/event_keyed_state_table_top_test.sv */
// Testbench top for the event keyed state table: stimulus, idling and verdict.
module event_keyed_state_table_top_test;
  import ekst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [63:0] in_key_a = '0;
  logic [63:0] in_key_b = '0;
  logic [4:0]  in_index_a = '0;
  logic [4:0]  in_index_b = '0;
  logic        in_pending_flag = 1'b0;
  logic [47:0] in_current_time = '0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [4:0]  out_entry_index;
  logic [1:0]  out_entry_state;
  logic        out_entry_pending;
  logic [63:0] out_entry_key_normal;
  logic [63:0] out_entry_key_reverse;
  logic [47:0] out_entry_time;
  logic [5:0]  out_entry_count;
  logic        out_notify;
  logic        out_last;
  int          fail_count;
  int          pending_results;
  int          stale_reports;
  int          idle_cycles = 0;
  int          sent = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  logic [63:0] key_pool [16];
  logic [47:0] clock_us = 48'd1000;

  always #10 clk = ~clk;

  event_keyed_state_table_top dut (.*);
  event_keyed_state_table_checker checker_i (.*);

  // Receiver stall: phases of no stall, light, and heavy.
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send(action_t act, logic [63:0] ka, logic [63:0] kb, int ia, int ib,
                      bit pf, logic [47:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_key_a <= ka;
    in_key_b <= kb;
    in_index_a <= ia[4:0];
    in_index_b <= ib[4:0];
    in_pending_flag <= pf;
    in_current_time <= now;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_write(logic [31:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    logic [63:0] ka, kb;
    pick = $urandom_range(0, 99);
    ka = key_pool[$urandom_range(0, 15)];
    kb = key_pool[$urandom_range(0, 15)];
    if ($urandom_range(0, 9) == 0) ka = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) kb = {$urandom, $urandom};
    clock_us += $urandom_range(0, 3) == 0 ? 48'($urandom_range(0, 5000000)) : 48'd0;
    if (pick < 22)
      send(ACT_ADD, ka, kb, 0, 0, 0, clock_us);
    else if (pick < 30)
      send(ACT_REMOVE, 0, 0, $urandom_range(0, 31), 0, 0, clock_us);
    else if (pick < 38)
      send(ACT_SWAP, 0, 0, $urandom_range(0, 31), $urandom_range(0, 31), 0, clock_us);
    else if (pick < 60)
      send(ACT_EVENT, ka, 0, 0, 0, 0,
           $urandom_range(0, 19) == 0 ? 48'({$urandom, $urandom}) : clock_us);
    else if (pick < 70)
      send(ACT_FIND, ka, 0, 0, 0, 0, clock_us);
    else if (pick < 78)
      send(ACT_SETPEND, 0, 0, $urandom_range(0, 31), 0, 1'($urandom_range(0, 1)),
           clock_us);
    else if (pick < 90)
      send(ACT_STALE, {$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 31),
           $urandom_range(0, 31), 1'($urandom_range(0, 1)), clock_us);
    else
      send(ACT_READ, 0, 0, $urandom_range(0, 31), 0, 0, clock_us);
  endtask

  initial begin
    int i;
    for (i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    // Directed: empty-table errors, extremes, duplicates, full table.
    send(ACT_READ, 0, 0, 31, 0, 0, 0);
    send(ACT_REMOVE, 0, 0, 0, 0, 0, 0);
    send(ACT_EVENT, '1, 0, 0, 0, 0, '1);
    send(ACT_STALE, 0, 0, 0, 0, 0, '1);
    send(ACT_ADD, '0, '1, 0, 0, 0, 0);
    send(ACT_ADD, '0, 64'd5, 0, 0, 0, 0);
    send(ACT_ADD, 64'd7, '1, 0, 0, 0, 0);
    send(ACT_ADD, '1, '0, 0, 0, 0, 0);
    send(ACT_EVENT, '0, 0, 0, 0, 0, 48'd100);
    send(ACT_EVENT, '0 - 64'd0 + 64'h0, 0, 0, 0, 0, 48'd100);
    send(ACT_EVENT, '1, 0, 0, 0, 0, '1);
    send(ACT_FIND, '1, 0, 0, 0, 0, 0);
    send(ACT_SETPEND, 0, 0, 1, 0, 1, 0);
    send(ACT_READ, 0, 0, 1, 0, 0, 0);
    send(ACT_SWAP, 0, 0, 0, 1, 0, 0);
    send(ACT_SWAP, 0, 0, 1, 1, 0, 0);
    send(ACT_SWAP, 0, 0, 0, 31, 0, 0);
    send(ACT_REMOVE, 0, 0, 0, 0, 0, 0);
    for (i = 0; i < 33; i++) send(ACT_ADD, 64'(i) + 64'h100, 64'(i) + 64'h200, 0, 0, 0, 0);
    send(ACT_EVENT, 64'h21e, 0, 0, 0, 0, 48'd50);
    drain_and_write(32'd1);
    send(ACT_STALE, 0, 0, 0, 0, 0, 48'd40);
    send(ACT_STALE, 0, 0, 0, 0, 0, 48'd1050);
    send(ACT_STALE, 0, 0, 0, 0, 0, 48'd2000);
    send(ACT_REMOVE, 0, 0, 31, 0, 0, 0);
    for (i = 0; i < 31; i++) send(ACT_REMOVE, 0, 0, 0, 0, 0, 0);
    // Random phases over several timeout settings, extremes included.
    for (i = 0; i < 200; i++) begin
      if (i == 40) drain_and_write(32'hFFFF_FFFF);
      if (i == 80) drain_and_write(32'd0);
      if (i == 120) drain_and_write(32'd2);
      if (i == 160) drain_and_write(32'd500);
      random_item();
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Run covered %0d transactions over all eight actions and five timeouts,",
             sent);
    $display("including %0d entries reported stale.", stale_reports);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule

/* event_keyed_state_table_top.f */
+incdir+sv
sv/ekst_pkg.sv
sv/ekst_datapath.sv
sv/ekst_ctrl.sv
sv/event_keyed_state_table_top.sv
tb/event_keyed_state_table_checker.sv
tb/event_keyed_state_table_top_test.sv
